// ===== rtl/core/htfd_pkg.sv =====
package htfd_pkg;

  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcInit = 8'hFF;
  localparam logic [1:0] SensorTypeNoCrc = 2'd1;
  localparam logic [1:0] SensorTypeReset = 2'd2;
  localparam logic [2:0] LastIdxNoCrc = 3'd5;
  localparam logic [2:0] LastIdxCrc = 3'd6;
  localparam logic [20:0] HumClamp = 21'h100000;
  localparam logic [13:0] HumScale = 14'd10000;
  localparam logic [14:0] TempScale = 15'd20000;
  localparam logic [14:0] TempOffset = 15'd5000;

  typedef enum logic [1:0] {
    StatusOk     = 2'd0,
    StatusBusErr = 2'd1,
    StatusBusy   = 2'd2,
    StatusCrcErr = 2'd3
  } status_e;

  typedef struct packed {
    logic       bus_error;
    logic       frame_start;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [20:0] raw_h;
    logic [19:0] raw_t;
  } frame_res_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/humidity_temp_frame_decoder.sv =====
// Decodes readout frames of a humidity and temperature sensor, one byte per transfer.
// The slave stream carries the frame bytes; tuser flags the status byte that opens a
// frame and a failed bus transfer for the byte. The frame is 6 bytes long when
// cfg_wdata_i last wrote sensor type 1 and 7 bytes with a trailing CRC-8 otherwise.
// On the last byte of a frame, one transfer leaves on the master stream: the status
// code in tuser, and the raw and scaled humidity and temperature in tdata. A result
// with a nonzero status carries zeros in all data fields. Bytes outside a frame give
// no result, and a new status byte abandons an open frame.
// A frame's last byte and its result pass the input register, the frame tracker and
// the scaling stage in that order, each registered, before tvalid rises on the master side.
// One byte is accepted every cycle as long as the master side keeps taking results.
// When the receiver stalls, results wait in the pipeline registers and tready falls
// once the scaling stage and the frame tracker hold results that cannot move on and
// the input register holds a byte.
// Reset clears the frame state, empties the pipeline and sets the sensor type to 2.
// The sensor type may only be written while no frame is in progress.
module humidity_temp_frame_decoder import htfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  input  logic [1:0]  s_axis_tuser,   // frame_start, bus_error
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // raw_humidity[20:0], raw_temperature[40:21], humidity_centi_pct[54:41],
  // temp_centi_deg[69:55], zero fill[71:70]
  output logic [71:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // status_code
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i
);

  logic       in_vld_q;
  in_item_t   in_q;
  logic       item_rdy;
  logic [1:0] sensor_type_q;
  logic       res_vld;
  frame_res_t res;
  logic       res_rdy;

  assign s_axis_tready = !in_vld_q || item_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      sensor_type_q <= SensorTypeReset;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (cfg_we_i) begin
        sensor_type_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.rx_byte <= s_axis_tdata;
      in_q.frame_start <= s_axis_tuser[0];
      in_q.bus_error <= s_axis_tuser[1];
    end
  end

  htfd_frame u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_vld_i   (in_vld_q),
    .item_i       (in_q),
    .item_rdy_o   (item_rdy),
    .sensor_type_i(sensor_type_q),
    .res_vld_o    (res_vld),
    .res_o        (res),
    .res_rdy_i    (res_rdy)
  );

  htfd_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_vld_i   (res_vld),
    .res_i       (res),
    .res_rdy_o   (res_rdy),
    .out_vld_o   (m_axis_tvalid),
    .out_status_o(m_axis_tuser),
    .out_data_o  (m_axis_tdata),
    .out_rdy_i   (m_axis_tready)
  );

endmodule

// ===== rtl/core/htfd_frame.sv =====
module htfd_frame import htfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_vld_i,
  input  in_item_t   item_i,
  output logic       item_rdy_o,
  input  logic [1:0] sensor_type_i,
  output logic       res_vld_o,
  output frame_res_t res_o,
  input  logic       res_rdy_i
);

  logic [2:0]  idx_q, idx_d;
  logic [7:0]  crc_q, crc_d;
  logic        busy_q, busy_d;
  logic        err_q, err_d;
  logic        active_q, active_d;
  logic [39:0] payload_q, payload_d;
  logic        res_vld_q, res_vld_d;
  frame_res_t  res_q, res_d;

  logic        fire;
  logic        with_crc;
  logic [2:0]  last_idx;
  logic [2:0]  idx_e;
  logic [7:0]  crc_e;
  logic        take;
  logic        produce;
  logic [20:0] raw_h;
  status_e     status;

  assign item_rdy_o = !res_vld_q || res_rdy_i;
  assign fire = item_vld_i && item_rdy_o;
  assign with_crc = (sensor_type_i != SensorTypeNoCrc);
  assign last_idx = with_crc ? LastIdxCrc : LastIdxNoCrc;
  assign idx_e = item_i.frame_start ? 3'd0 : idx_q;
  assign crc_e = item_i.frame_start ? CrcInit : crc_q;
  assign take = fire && (item_i.frame_start || active_q);
  assign produce = take && (idx_e >= last_idx);

  always_comb begin
    idx_d = idx_q;
    crc_d = crc_q;
    busy_d = busy_q;
    err_d = err_q;
    active_d = active_q;
    payload_d = payload_q;
    if (take) begin
      err_d = (item_i.frame_start ? 1'b0 : err_q) | item_i.bus_error;
      busy_d = (idx_e == 3'd0) ? item_i.rx_byte[7] : (item_i.frame_start ? 1'b0 : busy_q);
      case (idx_e)
        3'd1: payload_d[39:32] = item_i.rx_byte;
        3'd2: payload_d[31:24] = item_i.rx_byte;
        3'd3: payload_d[23:16] = item_i.rx_byte;
        3'd4: payload_d[15:8] = item_i.rx_byte;
        3'd5: payload_d[7:0] = item_i.rx_byte;
        default: ;
      endcase
      if (produce) begin
        active_d = 1'b0;
        idx_d = 3'd0;
        crc_d = CrcInit;
      end else begin
        active_d = 1'b1;
        idx_d = idx_e + 3'd1;
        crc_d = crc8_byte(crc_e, item_i.rx_byte);
      end
    end
  end

  always_comb begin
    if (err_d) begin
      status = StatusBusErr;
    end else if (busy_d) begin
      status = StatusBusy;
    end else if (with_crc && (crc_e != item_i.rx_byte)) begin
      status = StatusCrcErr;
    end else begin
      status = StatusOk;
    end
    raw_h = {1'b0, payload_d[39:20]};
    if (raw_h > HumClamp) begin
      raw_h = HumClamp;
    end
    res_d.status = status;
    res_d.raw_h = (status == StatusOk) ? raw_h : 21'd0;
    res_d.raw_t = (status == StatusOk) ? payload_d[19:0] : 20'd0;
  end

  assign res_vld_d = (res_vld_q && !res_rdy_i) || produce;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 3'd0;
      crc_q <= CrcInit;
      busy_q <= 1'b0;
      err_q <= 1'b0;
      active_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      crc_q <= crc_d;
      busy_q <= busy_d;
      err_q <= err_d;
      active_q <= active_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    payload_q <= payload_d;
    if (produce) begin
      res_q <= res_d;
    end
  end

  assign res_vld_o = res_vld_q;
  assign res_o = res_q;

endmodule

// ===== rtl/core/htfd_scale.sv =====
module htfd_scale import htfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        res_vld_i,
  input  frame_res_t  res_i,
  output logic        res_rdy_o,
  output logic        out_vld_o,
  output logic [1:0]  out_status_o,
  output logic [71:0] out_data_o,
  input  logic        out_rdy_i
);

  logic        out_vld_q, out_vld_d;
  logic [1:0]  status_q;
  logic [71:0] data_q;
  logic        load;
  logic [34:0] hum_prod;
  logic [34:0] temp_prod;
  logic [13:0] hum;
  logic [14:0] temp;
  logic        ok;

  assign res_rdy_o = !out_vld_q || out_rdy_i;
  assign load = res_vld_i && res_rdy_o;
  assign ok = (res_i.status == StatusOk);

  assign hum_prod = 35'(res_i.raw_h) * 35'(HumScale);
  assign temp_prod = 35'(res_i.raw_t) * 35'(TempScale);
  assign hum = ok ? hum_prod[33:20] : 14'd0;
  assign temp = ok ? (temp_prod[34:20] - TempOffset) : 15'd0;

  assign out_vld_d = (out_vld_q && !out_rdy_i) || res_vld_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_rdy_o) begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q <= res_i.status;
      data_q <= {2'b00, temp, hum, res_i.raw_t, res_i.raw_h};
    end
  end

  assign out_vld_o = out_vld_q;
  assign out_status_o = status_q;
  assign out_data_o = data_q;

endmodule
